### design/assert_macros.svh
// Assertion macros used by the top level of the key extractor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset
`define QKFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qkfe: implication check failed");
// Next-cycle implication under reset
`define QKFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qkfe: next-cycle check failed");
`else
`define QKFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QKFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/qkfe_pkg.sv
// Shared constants, types and helpers of the query key field extractor
`default_nettype none

package qkfe_pkg;

  // Value lengths and coordinate window
  localparam int SERIAL_CHARS = 16;
  localparam int DIGEST_CHARS = 32;
  localparam int COORD_WINDOW = 11;
  localparam int COORD_DEPTH  = COORD_WINDOW - 1;

  // Derived widths
  localparam int SER_W = $clog2(SERIAL_CHARS + 1);
  localparam int DIG_W = $clog2(DIGEST_CHARS + 1);
  localparam int CNT_W = $clog2(COORD_DEPTH + 1);
  localparam int IDX_W = (COORD_DEPTH > 1) ? $clog2(COORD_DEPTH) : 1;

  localparam int BYTE_W     = 8;
  localparam int HIST_BYTES = 5;
  localparam int CFG_W      = 10;
  localparam logic [CFG_W-1:0] CFG_RESET = 10'd64;
  localparam int OUT_TDATA_W = 24;

  // Field codes
  localparam logic [2:0] FIELD_SERIAL  = 3'd0;
  localparam logic [2:0] FIELD_DIGEST  = 3'd1;
  localparam logic [2:0] FIELD_X       = 3'd2;
  localparam logic [2:0] FIELD_Y       = 3'd3;
  localparam logic [2:0] FIELD_SUMMARY = 3'd4;

  // Request status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_CMD = 2'd1;
  localparam logic [1:0] STATUS_SHORT  = 2'd2;

  // Coordinate terminators
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;

  // Work left for the emitter by one input word
  typedef struct packed {
    logic              ser_v;
    logic              ser_done;
    logic              dig_v;
    logic              dig_done;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  x_n;
    logic [CNT_W-1:0]  y_n;
    logic              sum_v;
    logic [3:0]        mask;
    logic [1:0]        errs;
    logic [1:0]        status;
  } bundle_t;

  // Coordinate store read addresses from the emitter
  typedef struct packed {
    logic [IDX_W-1:0] x_idx;
    logic [IDX_W-1:0] y_idx;
  } coord_rd_t;

  // One result word
  typedef struct packed {
    logic [2:0]        code;
    logic [BYTE_W-1:0] value;
    logic              done;
    logic [3:0]        mask;
    logic [1:0]        errs;
    logic [1:0]        status;
    logic              last;
  } res_t;

  // Fold upper case letters to lower case
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= "A" && b <= "Z") begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/query_key_field_extractor.sv
// Top level of the query key field extractor
// Usage:
//   Request text enters on the s_axis channel, one character per word, with
//   s_axis_tlast_i high on the last character of a request. Results leave on
//   the m_axis channel: tuser carries the field code, tdata the value byte and
//   the summary fields, tlast marks the last result caused by one input word.
//   A word travels through an input register, a parse stage that updates the
//   matchers and loads the result emitter, and the output register; its first
//   result is presented once the emitter has passed it to the output register.
//   The emitter hands out one result per cycle while the receiver is ready, so a
//   word that causes at most one result lets the next word in every cycle. A word
//   that causes several results (serial and digest bytes, both coordinate values and
//   the summary, up to 23) holds the input until the emitter has handed out the last.
//   When the receiver stalls, the output register holds its word, the emitter
//   holds its pending results, and the input side stops once the input
//   register is full. cfg_wr_en_i writes the minimum byte count after the
//   command word; write it only while the block is idle.
//   Reset clears all matcher state, empties every stage and sets the
//   minimum byte count to 64. Coordinate stores are not cleared.
`default_nettype none
`include "assert_macros.svh"

module query_key_field_extractor import qkfe_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config: minimum byte count after the command word
  input  wire logic                   cfg_wr_en_i,
  input  wire logic [CFG_W-1:0]       cfg_wr_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  input  wire logic [BYTE_W-1:0]      s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                   s_axis_tlast_i,  // end_of_request
  // output stream
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [7:0] value_byte, [8] field_done, [12:9] found_mask,
  // [14:13] coord_errors, [16:15] request_status, [23:17] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output      logic [2:0]             m_axis_tuser_o,  // field_code
  output      logic                   m_axis_tlast_o   // last_of_run
);

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              s_accept;
  logic              step_go;
  logic              bundle_free;
  bundle_t           bundle;
  coord_rd_t         coord_rd;
  logic [BYTE_W-1:0] x_data, y_data;
  res_t              res;
  logic              res_summary;
  logic              res_value;
  logic              res_clean;
  logic              in_held;

  assign step_go         = in_valid_q && bundle_free;
  assign s_axis_tready_o = !in_valid_q || step_go;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (step_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Parse stage
  qkfe_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .step_i        (step_go),
    .data_i        (in_data_q),
    .eor_i         (in_last_q),
    .rd_i          (coord_rd),
    .x_data_o      (x_data),
    .y_data_o      (y_data),
    .bundle_o      (bundle)
  );

  // Result emitter and output register
  qkfe_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_go),
    .bundle_i    (bundle),
    .x_data_i    (x_data),
    .y_data_i    (y_data),
    .out_ready_i (m_axis_tready_i),
    .rd_o        (coord_rd),
    .free_o      (bundle_free),
    .out_valid_o (m_axis_tvalid_o),
    .res_o       (res)
  );

  // Pack the result word
  assign m_axis_tdata_o = {7'b0, res.status, res.errs, res.mask, res.done, res.value};
  assign m_axis_tuser_o = res.code;
  assign m_axis_tlast_o = res.last;

  // Checks
  assign res_summary = m_axis_tvalid_o && (res.code == FIELD_SUMMARY);
  assign res_value   = m_axis_tvalid_o && (res.code != FIELD_SUMMARY);
  assign res_clean   = (res.mask == 4'd0) && (res.errs == 2'd0) && (res.status == STATUS_OK);
  assign in_held     = in_valid_q && !step_go;

  `QKFE_ASSERT_IMP(a_summary_ends_run, clk_i, rst_ni, res_summary, res.last)
  `QKFE_ASSERT_NXT(a_in_word_held, clk_i, rst_ni, in_held, in_valid_q)
  `QKFE_ASSERT_IMP(a_value_no_summary, clk_i, rst_ni, res_value, res_clean)

endmodule

`default_nettype wire

### design/qkfe_parser.sv
// Request parser: matchers, capture state and coordinate stores
`default_nettype none

module qkfe_parser import qkfe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_wr_en_i,
  input  wire logic [CFG_W-1:0]  cfg_wr_data_i,
  input  wire logic              step_i,
  input  wire logic [BYTE_W-1:0] data_i,
  input  wire logic              eor_i,
  input  wire coord_rd_t         rd_i,
  output      logic [BYTE_W-1:0] x_data_o,
  output      logic [BYTE_W-1:0] y_data_o,
  output      bundle_t           bundle_o
);

  localparam logic [CFG_W-1:0] BSC_MAX  = {CFG_W{1'b1}};
  localparam logic [CFG_W-1:0] LONG_MIN = CFG_W'(7);
  localparam logic [CFG_W-1:0] MD5_MIN  = CFG_W'(4);

  logic [CFG_W-1:0] min_q;
  logic [HIST_BYTES-1:0][BYTE_W-1:0] recent_q, recent_d;
  logic cmd_seen_q, cmd_seen_d;
  logic [CFG_W-1:0] bsc_q, bsc_d;
  logic [SER_W-1:0] ser_rem_q, ser_rem_d;
  logic [DIG_W-1:0] dig_rem_q, dig_rem_d;
  logic [CNT_W-1:0] x_cnt_q, x_cnt_d, y_cnt_q, y_cnt_d;
  logic [3:0] found_q, found_d;
  logic [1:0] err_q, err_d;
  logic [3:0] hit_q, hit_d;
  logic [3:0] skip_q, skip_d;
  logic [1:0] act_q, act_d;
  logic x_we, y_we;
  logic [BYTE_W-1:0] x_store [COORD_DEPTH];
  logic [BYTE_W-1:0] y_store [COORD_DEPTH];
  logic [5:0][BYTE_W-1:0] win;
  logic term;
  logic cmd_hit, ser_hit, md5_hit, x_hit, y_hit;
  bundle_t bnd;

  // Folded view of the last six bytes, newest first
  always_comb begin
    win[0] = fold_case(data_i);
    for (int i = 1; i < 6; i++) begin
      win[i] = fold_case(recent_q[i-1]);
    end
  end

  assign term = (data_i == CH_SPACE) || (data_i == CH_AMP);

  // Word compares
  assign cmd_hit = (win[4] == "n") && (win[3] == "a") && (win[2] == "v") &&
                   (win[1] == "t") && (win[0] == "o");
  assign ser_hit = (win[5] == "s") && (win[4] == "e") && (win[3] == "r") &&
                   (win[2] == "i") && (win[1] == "a") && (win[0] == "l");
  assign md5_hit = (win[2] == "m") && (win[1] == "d") && (data_i == "5");
  assign x_hit   = (win[5] == "x") && (win[4] == "b") && (win[3] == "a") &&
                   (win[2] == "i") && (win[1] == "d") && (win[0] == "u");
  assign y_hit   = (win[5] == "y") && (win[4] == "b") && (win[3] == "a") &&
                   (win[2] == "i") && (win[1] == "d") && (win[0] == "u");

  // Next state and emitter work for one word
  always_comb begin
    recent_d   = recent_q;
    cmd_seen_d = cmd_seen_q;
    bsc_d      = bsc_q;
    ser_rem_d  = ser_rem_q;
    dig_rem_d  = dig_rem_q;
    x_cnt_d    = x_cnt_q;
    y_cnt_d    = y_cnt_q;
    found_d    = found_q;
    err_d      = err_q;
    hit_d      = hit_q;
    skip_d     = skip_q;
    act_d      = act_q;
    x_we       = 1'b0;
    y_we       = 1'b0;
    bnd        = '0;
    bnd.data   = data_i;

    if (step_i) begin
      recent_d = {recent_q[HIST_BYTES-2:0], data_i};

      // Serial value
      if (ser_rem_q != '0) begin
        bnd.ser_v    = 1'b1;
        bnd.ser_done = (ser_rem_q == SER_W'(1));
        ser_rem_d    = ser_rem_q - SER_W'(1);
        if (ser_rem_q == SER_W'(1)) begin
          found_d[0] = 1'b1;
        end
      end else if (skip_q[0]) begin
        skip_d[0] = 1'b0;
        ser_rem_d = SER_W'(SERIAL_CHARS);
      end

      // Digest value
      if (dig_rem_q != '0) begin
        bnd.dig_v    = 1'b1;
        bnd.dig_done = (dig_rem_q == DIG_W'(1));
        dig_rem_d    = dig_rem_q - DIG_W'(1);
        if (dig_rem_q == DIG_W'(1)) begin
          found_d[1] = 1'b1;
        end
      end else if (skip_q[1]) begin
        skip_d[1] = 1'b0;
        dig_rem_d = DIG_W'(DIGEST_CHARS);
      end

      // X coordinate capture
      if (act_q[0]) begin
        if (term) begin
          bnd.x_n    = x_cnt_q;
          found_d[2] = 1'b1;
          act_d[0]   = 1'b0;
        end else if (x_cnt_q < CNT_W'(COORD_DEPTH)) begin
          x_we    = 1'b1;
          x_cnt_d = x_cnt_q + CNT_W'(1);
        end else begin
          err_d[0] = 1'b1;
          act_d[0] = 1'b0;
        end
      end else if (skip_q[2]) begin
        skip_d[2] = 1'b0;
        act_d[0]  = 1'b1;
        x_cnt_d   = '0;
      end

      // Y coordinate capture
      if (act_q[1]) begin
        if (term) begin
          bnd.y_n    = y_cnt_q;
          found_d[3] = 1'b1;
          act_d[1]   = 1'b0;
        end else if (y_cnt_q < CNT_W'(COORD_DEPTH)) begin
          y_we    = 1'b1;
          y_cnt_d = y_cnt_q + CNT_W'(1);
        end else begin
          err_d[1] = 1'b1;
          act_d[1] = 1'b0;
        end
      end else if (skip_q[3]) begin
        skip_d[3] = 1'b0;
        act_d[1]  = 1'b1;
        y_cnt_d   = '0;
      end

      // Command word, then first hit of each key
      if (cmd_seen_q) begin
        if (bsc_q != BSC_MAX) begin
          bsc_d = bsc_q + CFG_W'(1);
        end
        if (!hit_q[0] && ser_hit && (bsc_d >= LONG_MIN)) begin
          hit_d[0]  = 1'b1;
          skip_d[0] = 1'b1;
        end
        if (!hit_q[1] && md5_hit && (bsc_d >= MD5_MIN)) begin
          hit_d[1]  = 1'b1;
          skip_d[1] = 1'b1;
        end
        if (!hit_q[2] && x_hit && (bsc_d >= LONG_MIN)) begin
          hit_d[2]  = 1'b1;
          skip_d[2] = 1'b1;
        end
        if (!hit_q[3] && y_hit && (bsc_d >= LONG_MIN)) begin
          hit_d[3]  = 1'b1;
          skip_d[3] = 1'b1;
        end
      end else if (cmd_hit) begin
        cmd_seen_d = 1'b1;
        bsc_d      = '0;
      end

      // Summary, then restart for the next request
      if (eor_i) begin
        bnd.sum_v = 1'b1;
        bnd.mask  = found_d;
        bnd.errs  = err_d;
        if (!cmd_seen_d) begin
          bnd.status = STATUS_NO_CMD;
        end else if (bsc_d <= min_q) begin
          bnd.status = STATUS_SHORT;
        end else begin
          bnd.status = STATUS_OK;
        end
        recent_d   = '0;
        cmd_seen_d = 1'b0;
        bsc_d      = '0;
        ser_rem_d  = '0;
        dig_rem_d  = '0;
        x_cnt_d    = '0;
        y_cnt_d    = '0;
        found_d    = '0;
        err_d      = '0;
        hit_d      = '0;
        skip_d     = '0;
        act_d      = '0;
      end
    end
  end

  assign bundle_o = bnd;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= CFG_RESET;
      recent_q   <= '0;
      cmd_seen_q <= 1'b0;
      bsc_q      <= '0;
      ser_rem_q  <= '0;
      dig_rem_q  <= '0;
      x_cnt_q    <= '0;
      y_cnt_q    <= '0;
      found_q    <= '0;
      err_q      <= '0;
      hit_q      <= '0;
      skip_q     <= '0;
      act_q      <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        min_q <= cfg_wr_data_i;
      end
      recent_q   <= recent_d;
      cmd_seen_q <= cmd_seen_d;
      bsc_q      <= bsc_d;
      ser_rem_q  <= ser_rem_d;
      dig_rem_q  <= dig_rem_d;
      x_cnt_q    <= x_cnt_d;
      y_cnt_q    <= y_cnt_d;
      found_q    <= found_d;
      err_q      <= err_d;
      hit_q      <= hit_d;
      skip_q     <= skip_d;
      act_q      <= act_d;
    end
  end

  // Coordinate stores, no reset
  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_store[x_cnt_q[IDX_W-1:0]] <= data_i;
    end
    if (y_we) begin
      y_store[y_cnt_q[IDX_W-1:0]] <= data_i;
    end
  end

  assign x_data_o = x_store[rd_i.x_idx];
  assign y_data_o = y_store[rd_i.y_idx];

endmodule

`default_nettype wire

### design/qkfe_emitter.sv
// Result emitter: holds one word's pending results and feeds the output register
`default_nettype none

module qkfe_emitter import qkfe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire bundle_t           bundle_i,
  input  wire logic [BYTE_W-1:0] x_data_i,
  input  wire logic [BYTE_W-1:0] y_data_i,
  input  wire logic              out_ready_i,
  output      coord_rd_t         rd_o,
  output      logic              free_o,
  output      logic              out_valid_o,
  output      res_t              res_o
);

  bundle_t bnd_q;
  logic [CNT_W-1:0] x_i_q, y_i_q;
  logic [CNT_W-1:0] x_i_nx, y_i_nx;
  logic x_pend, y_pend;
  logic pick_v;
  res_t pick;
  logic out_load;
  logic out_valid_q;
  res_t res_q;

  assign x_pend = (x_i_q != bnd_q.x_n);
  assign y_pend = (y_i_q != bnd_q.y_n);
  assign x_i_nx = x_i_q + CNT_W'(1);
  assign y_i_nx = y_i_q + CNT_W'(1);

  assign rd_o.x_idx = x_i_q[IDX_W-1:0];
  assign rd_o.y_idx = y_i_q[IDX_W-1:0];

  // Pick the next pending result in field order
  always_comb begin
    pick   = '0;
    pick_v = 1'b1;
    if (bnd_q.ser_v) begin
      pick.code  = FIELD_SERIAL;
      pick.value = bnd_q.data;
      pick.done  = bnd_q.ser_done;
      pick.last  = !bnd_q.dig_v && !x_pend && !y_pend && !bnd_q.sum_v;
    end else if (bnd_q.dig_v) begin
      pick.code  = FIELD_DIGEST;
      pick.value = bnd_q.data;
      pick.done  = bnd_q.dig_done;
      pick.last  = !x_pend && !y_pend && !bnd_q.sum_v;
    end else if (x_pend) begin
      pick.code  = FIELD_X;
      pick.value = x_data_i;
      pick.done  = (x_i_nx == bnd_q.x_n);
      pick.last  = (x_i_nx == bnd_q.x_n) && !y_pend && !bnd_q.sum_v;
    end else if (y_pend) begin
      pick.code  = FIELD_Y;
      pick.value = y_data_i;
      pick.done  = (y_i_nx == bnd_q.y_n);
      pick.last  = (y_i_nx == bnd_q.y_n) && !bnd_q.sum_v;
    end else if (bnd_q.sum_v) begin
      pick.code   = FIELD_SUMMARY;
      pick.mask   = bnd_q.mask;
      pick.errs   = bnd_q.errs;
      pick.status = bnd_q.status;
      pick.last   = 1'b1;
    end else begin
      pick_v = 1'b0;
    end
  end

  assign out_load = pick_v && (!out_valid_q || out_ready_i);
  assign free_o   = !pick_v || (out_load && pick.last);

  // Advance through pending results, or take a new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q <= '0;
      x_i_q <= '0;
      y_i_q <= '0;
    end else if (load_i) begin
      bnd_q <= bundle_i;
      x_i_q <= '0;
      y_i_q <= '0;
    end else if (out_load) begin
      if (bnd_q.ser_v) begin
        bnd_q.ser_v <= 1'b0;
      end else if (bnd_q.dig_v) begin
        bnd_q.dig_v <= 1'b0;
      end else if (x_pend) begin
        x_i_q <= x_i_nx;
      end else if (y_pend) begin
        y_i_q <= y_i_nx;
      end else begin
        bnd_q.sum_v <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= pick;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
